### rtl/ss_pkg.sv
// ss_pkg: shared types and codes for the searchable stack
// transaction payload structs, operation and status codes, cell chain token
// no dependencies
package ss_pkg;

  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_COUNT  = 3'd2;
  localparam logic [2:0] KIND_LOCATE = 3'd3;
  localparam logic [2:0] KIND_FILL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [4:0]  range_start;
    logic [4:0]  range_end;
  } item_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [4:0]  match_count;
    logic [4:0]  found_index;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  fill_level;
  } result_t;

  // control part of the token that walks along the cell chain
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       act;
    logic [4:0] lo;
    logic [4:0] hi;
  } tok_t;

endpackage

### rtl/ss_cell.sv
// ss_cell: one stack entry with its local compare, count, locate and fill logic
// registers the token and running totals and hands them to the next cell
// depends on ss_pkg
module ss_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ss_pkg::tok_t          tok_in,
  input  logic [CNT_W-1:0]      top_in,
  input  logic [WORD_WIDTH-1:0] key_in,
  input  logic [WORD_WIDTH-1:0] run_in,
  input  logic [WORD_WIDTH-1:0] popped_in,
  input  logic [CNT_W-1:0]      cnt_in,
  input  logic [CNT_W-1:0]      where_in,
  input  logic                  hit_in,
  output ss_pkg::tok_t          tok_out,
  output logic [CNT_W-1:0]      top_out,
  output logic [WORD_WIDTH-1:0] key_out,
  output logic [WORD_WIDTH-1:0] run_out,
  output logic [WORD_WIDTH-1:0] popped_out,
  output logic [CNT_W-1:0]      cnt_out,
  output logic [CNT_W-1:0]      where_out,
  output logic                  hit_out
);

  localparam int CW = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] IDX   = CNT_W'(INDEX);
  localparam logic [CW-1:0]    IDX_W = CW'(INDEX);

  logic [WORD_WIDTH-1:0] entry;
  logic                  live;
  logic                  match;
  logic                  is_top;
  logic                  in_rng;

  always_comb begin
    live   = IDX < top_in;
    match  = live && (entry == key_in);
    is_top = IDX == top_in;
    in_rng = (IDX_W >= CW'(tok_in.lo)) && (IDX_W < CW'(tok_in.hi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    top_out    <= top_in;
    key_out    <= key_in;
    run_out    <= run_in;
    popped_out <= popped_in;
    cnt_out    <= cnt_in;
    where_out  <= where_in;
    hit_out    <= hit_in;
    if (tok_in.valid) begin
      case (tok_in.kind)
        ss_pkg::KIND_PUSH: begin
          if (tok_in.act && is_top) entry <= key_in;
        end
        ss_pkg::KIND_POP: begin
          if (tok_in.act && is_top) popped_out <= entry;
        end
        ss_pkg::KIND_COUNT: begin
          if (match) cnt_out <= CNT_W'(cnt_in + 1'b1);
        end
        ss_pkg::KIND_LOCATE: begin
          if (match && !hit_in) begin
            hit_out   <= 1'b1;
            where_out <= IDX;
          end
        end
        ss_pkg::KIND_FILL: begin
          if (tok_in.act && in_rng) begin
            entry   <= run_in;
            run_out <= WORD_WIDTH'(run_in + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/searchable_stack.sv
// searchable_stack: lifo stack with count, locate and range fill over a cell chain
// top level: fill tracking, status decode, result register
// depends on ss_pkg and ss_cell
//
// usage
//   item channel: item_valid / item_ready carry one operation (push, pop, count,
//   locate, range fill) as ss_pkg::item_t
//   result channel: result_valid / result_ready return exactly one ss_pkg::result_t
//   per item, in order
//   each item walks the chain of DEPTH cells, one cell per cycle; the result is
//   registered from the chain tail; one item is in flight at a time, so a new
//   item is not taken while the previous one is still in the chain
//   the result register holds its transaction while result_ready is low; a new
//   item is taken once the chain is empty and the result register is empty or
//   being emptied in the same cycle
//   reset empties the stack (fill level zero) and drops any transaction in
//   flight; entry contents are not cleared
module searchable_stack #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ss_pkg::item_t    item,
  output logic             result_valid,
  input  logic             result_ready,
  output ss_pkg::result_t  result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

  logic [CNT_W-1:0] top_count;
  logic [CNT_W-1:0] top_next;
  logic             busy;
  logic [2:0]       pend_kind;
  logic [1:0]       pend_status;
  logic [CNT_W-1:0] pend_fill;
  logic             accept;
  logic [1:0]       status_c;
  logic             full;
  logic             empty;
  logic [CW-1:0]    lo_w;
  logic [CW-1:0]    hi_w;
  logic [CW-1:0]    top_w;

  logic [WORD_WIDTH+31:0] key_ext;
  logic [WORD_WIDTH+31:0] pop_ext;
  logic [CNT_W+4:0]       cnt_ext;
  logic [CNT_W+4:0]       where_ext;
  logic [CNT_W+4:0]       fill_ext;
  logic [CNT_W-1:0]       where_sel;

  ss_pkg::tok_t          tok    [DEPTH+1];
  logic [CNT_W-1:0]      top_c  [DEPTH+1];
  logic [WORD_WIDTH-1:0] key_c  [DEPTH+1];
  logic [WORD_WIDTH-1:0] run_c  [DEPTH+1];
  logic [WORD_WIDTH-1:0] pop_c  [DEPTH+1];
  logic [CNT_W-1:0]      cnt_c  [DEPTH+1];
  logic [CNT_W-1:0]      whr_c  [DEPTH+1];
  logic                  hit_c  [DEPTH+1];

  assign item_ready = !busy && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  always_comb begin
    full     = top_count == CNT_W'(DEPTH);
    empty    = top_count == '0;
    lo_w     = CW'(item.range_start);
    hi_w     = CW'(item.range_end);
    top_w    = CW'(top_count);
    status_c = ss_pkg::ST_OK;
    top_next = top_count;
    case (item.kind)
      ss_pkg::KIND_PUSH: begin
        if (full) status_c = ss_pkg::ST_OVER;
        else      top_next = CNT_W'(top_count + 1'b1);
      end
      ss_pkg::KIND_POP: begin
        if (empty) status_c = ss_pkg::ST_UNDER;
        else       top_next = CNT_W'(top_count - 1'b1);
      end
      ss_pkg::KIND_FILL: begin
        if ((lo_w > hi_w) || (hi_w > top_w)) status_c = ss_pkg::ST_RANGE;
      end
      default: begin
      end
    endcase
  end

  // chain head
  assign key_ext       = {WORD_WIDTH'(0), item.value};
  assign tok[0].valid  = accept;
  assign tok[0].kind   = item.kind;
  assign tok[0].act    = status_c == ss_pkg::ST_OK;
  assign tok[0].lo     = item.range_start;
  assign tok[0].hi     = item.range_end;
  assign top_c[0]      = (item.kind == ss_pkg::KIND_POP) ? top_next : top_count;
  assign key_c[0]      = key_ext[WORD_WIDTH-1:0];
  assign run_c[0]      = key_ext[WORD_WIDTH-1:0];
  assign pop_c[0]      = '0;
  assign cnt_c[0]      = '0;
  assign whr_c[0]      = '0;
  assign hit_c[0]      = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ss_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[i]),
      .top_in     (top_c[i]),
      .key_in     (key_c[i]),
      .run_in     (run_c[i]),
      .popped_in  (pop_c[i]),
      .cnt_in     (cnt_c[i]),
      .where_in   (whr_c[i]),
      .hit_in     (hit_c[i]),
      .tok_out    (tok[i+1]),
      .top_out    (top_c[i+1]),
      .key_out    (key_c[i+1]),
      .run_out    (run_c[i+1]),
      .popped_out (pop_c[i+1]),
      .cnt_out    (cnt_c[i+1]),
      .where_out  (whr_c[i+1]),
      .hit_out    (hit_c[i+1])
    );
  end

  // chain tail
  always_comb begin
    if (pend_kind != ss_pkg::KIND_LOCATE) where_sel = '0;
    else if (hit_c[DEPTH])                where_sel = whr_c[DEPTH];
    else                                  where_sel = CNT_W'(DEPTH);
  end

  assign pop_ext   = {32'b0, pop_c[DEPTH]};
  assign cnt_ext   = {5'b0, cnt_c[DEPTH]};
  assign where_ext = {5'b0, where_sel};
  assign fill_ext  = {5'b0, pend_fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count    <= '0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        top_count <= top_next;
        busy      <= 1'b1;
      end
      if (tok[DEPTH].valid) begin
        busy         <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_kind   <= item.kind;
      pend_status <= status_c;
      pend_fill   <= top_next;
    end
    if (tok[DEPTH].valid) begin
      result.popped_value <= pop_ext[31:0];
      result.match_count  <= cnt_ext[4:0];
      result.found_index  <= where_ext[4:0];
      result.found        <= hit_c[DEPTH];
      result.status       <= pend_status;
      result.fill_level   <= fill_ext[4:0];
    end
  end

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for searchable_stack with an in-bench stack predictor
// random bursts on the item side, random stalls and one long hold-off on the result side
// depends on ss_pkg and the searchable_stack rtl

localparam int STACK_DEPTH = 16;

class stack_scoreboard;
  logic [31:0]     words[STACK_DEPTH];
  int              live;
  ss_pkg::result_t results_due[$];
  int              mismatches;
  int              results_checked;

  function new();
    foreach (words[i]) words[i] = '0;
    live            = 0;
    mismatches      = 0;
    results_checked = 0;
  endfunction

  function ss_pkg::result_t apply_stack_op(ss_pkg::item_t it);
    ss_pkg::result_t r;
    logic [31:0]     run;
    r = '0;
    case (it.kind)
      ss_pkg::KIND_PUSH: begin
        if (live == STACK_DEPTH) begin
          r.status = ss_pkg::ST_OVER;
        end else begin
          words[live] = it.value;
          live++;
        end
      end
      ss_pkg::KIND_POP: begin
        if (live == 0) begin
          r.status = ss_pkg::ST_UNDER;
        end else begin
          live--;
          r.popped_value = words[live];
        end
      end
      ss_pkg::KIND_COUNT: begin
        for (int i = 0; i < live; i++)
          if (words[i] == it.value) r.match_count = r.match_count + 5'd1;
      end
      ss_pkg::KIND_LOCATE: begin
        r.found_index = 5'(STACK_DEPTH);
        for (int i = 0; i < live; i++) begin
          if (!r.found && words[i] == it.value) begin
            r.found_index = 5'(i);
            r.found       = 1'b1;
          end
        end
      end
      ss_pkg::KIND_FILL: begin
        if (it.range_start > it.range_end || int'(it.range_end) > live) begin
          r.status = ss_pkg::ST_RANGE;
        end else begin
          run = it.value;
          for (int i = int'(it.range_start); i < int'(it.range_end); i++) begin
            words[i] = run;
            run      = run + 32'd1;
          end
        end
      end
      default: ;
    endcase
    r.fill_level = 5'(live);
    return r;
  endfunction

  function void note_item(ss_pkg::item_t it);
    results_due.push_back(apply_stack_op(it));
  endfunction

  function void check_result(ss_pkg::result_t got);
    ss_pkg::result_t want;
    results_checked++;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transaction %h with nothing outstanding", got);
      return;
    end
    want = results_due.pop_front();
    if (got.popped_value !== want.popped_value || got.match_count !== want.match_count ||
        got.found_index !== want.found_index || got.found !== want.found ||
        got.status !== want.status || got.fill_level !== want.fill_level) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result %0d mismatch: expected pop=%h cnt=%0d idx=%0d hit=%0b st=%0d ",
                  "fill=%0d, got pop=%h cnt=%0d idx=%0d hit=%0b st=%0d fill=%0d"},
                 results_checked, want.popped_value, want.match_count, want.found_index,
                 want.found, want.status, want.fill_level, got.popped_value,
                 got.match_count, got.found_index, got.found, got.status, got.fill_level);
    end
  endfunction
endclass

module tb_top;

  localparam int RANDOM_ITEMS = 550;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;

  logic            clk = 1'b0;
  logic            rst;
  logic            item_valid;
  logic            item_ready;
  ss_pkg::item_t   item;
  logic            result_valid;
  logic            result_ready;
  ss_pkg::result_t result;
  int              cycle_count = 0;

  stack_scoreboard sb = new();

  searchable_stack #(
    .DEPTH     (STACK_DEPTH),
    .WORD_WIDTH(32)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // results first, so a stray result is never matched against a new transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if (item_valid && item_ready) sb.note_item(item);
    end
  end

  function automatic ss_pkg::item_t mk_item(logic [2:0] kind, logic [31:0] value,
                                            logic [4:0] lo, logic [4:0] hi);
    ss_pkg::item_t it;
    it.kind        = kind;
    it.value       = value;
    it.range_start = lo;
    it.range_end   = hi;
    return it;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic ss_pkg::item_t next_random_item(bit grow);
    ss_pkg::item_t it;
    int unsigned   roll;
    int            lvl;
    lvl            = sb.live;
    it.kind        = ss_pkg::KIND_PUSH;
    it.value       = pick_word();
    it.range_start = 5'($urandom_range(0, 31));
    it.range_end   = 5'($urandom_range(0, 31));
    roll           = $urandom_range(0, 99);
    if (roll < (grow ? 40 : 15)) begin
      it.kind = ss_pkg::KIND_PUSH;
    end else if (roll < 55) begin
      it.kind = ss_pkg::KIND_POP;
    end else if (roll < 81) begin
      it.kind = (roll < 68) ? ss_pkg::KIND_COUNT : ss_pkg::KIND_LOCATE;
      if (lvl > 0 && $urandom_range(0, 2) != 0)
        it.value = sb.words[$urandom_range(0, lvl - 1)];
    end else if (roll < 95) begin
      it.kind = ss_pkg::KIND_FILL;
      if ($urandom_range(0, 4) != 0) begin
        it.range_end   = 5'($urandom_range(0, lvl));
        it.range_start = 5'($urandom_range(0, int'(it.range_end)));
      end
    end else begin
      it.kind = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic send_item(input ss_pkg::item_t it);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int burst;
    int sent;
    bit grow;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack corners
    send_item(mk_item(ss_pkg::KIND_POP, 32'h0, 5'd0, 5'd0));
    send_item(mk_item(ss_pkg::KIND_LOCATE, 32'h0, 5'd0, 5'd0));
    send_item(mk_item(ss_pkg::KIND_FILL, 32'h1234_5678, 5'd0, 5'd1));
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (i % 4)
        0:       send_item(mk_item(ss_pkg::KIND_PUSH, 32'h0, 5'd31, 5'd0));
        1:       send_item(mk_item(ss_pkg::KIND_PUSH, 32'hffff_ffff, 5'd0, 5'd31));
        2:       send_item(mk_item(ss_pkg::KIND_PUSH, 32'ha5a5_a5a5, 5'd10, 5'd21));
        default: send_item(mk_item(ss_pkg::KIND_PUSH, $urandom, 5'd0, 5'd0));
      endcase
    end
    // full stack corners, wrapping fill, range error, empty range, unused kind
    send_item(mk_item(ss_pkg::KIND_PUSH, 32'h5555_5555, 5'd0, 5'd0));
    send_item(mk_item(ss_pkg::KIND_FILL, 32'hffff_fffe, 5'd0, 5'd16));
    send_item(mk_item(ss_pkg::KIND_COUNT, 32'h0, 5'd0, 5'd0));
    send_item(mk_item(ss_pkg::KIND_LOCATE, 32'hffff_ffff, 5'd0, 5'd0));
    send_item(mk_item(ss_pkg::KIND_FILL, 32'h0, 5'd9, 5'd4));
    send_item(mk_item(ss_pkg::KIND_FILL, 32'h0, 5'd16, 5'd16));
    send_item(mk_item(3'd7, 32'hffff_ffff, 5'd31, 5'd31));
    send_item(mk_item(ss_pkg::KIND_POP, 32'h0, 5'd0, 5'd0));

    sent = 0;
    grow = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) grow = !grow;
      repeat (burst) begin
        send_item(next_random_item(grow));
        sent++;
      end
      pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
    end
    item_valid <= 1'b0;

    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("searchable_stack verification clean");
    end else begin
      $display("searchable_stack verification failed");
    end
    $finish;
  end

  // receiver: random ready/stall spans, plus one long hold-off to back up the input
  initial begin : result_sink
    bit long_hold_done;
    int span;
    long_hold_done = 1'b0;
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results_checked >= 150) begin
        long_hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 40);
        result_ready <= ($urandom_range(0, 2) != 0);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("searchable_stack verification failed");
    $finish;
  end

endmodule

### files.f
rtl/ss_pkg.sv
rtl/ss_cell.sv
rtl/searchable_stack.sv
verif/tb_top.sv
